[rtl/bdq_pkg.sv]
// ----------------------------------------------------------------------------
// bdq_pkg
// types, sizes and codes shared by the bounded deque modules
// ----------------------------------------------------------------------------
package bdq_pkg;

  // store depth and derived widths
  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  localparam int WORD_W = 32;

  // command codes
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_DUMP       = 3'd4;

  // result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]               cmd;
    logic signed [WORD_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] word;
    logic [1:0]               status;
    logic                     last;
  } out_item_t;

  // classified operation handed from front to back
  typedef struct packed {
    logic                     push;
    logic                     pop;
    logic                     dump;
    logic                     at_front;
    logic signed [WORD_W-1:0] value;
  } op_t;

  // ring index plus offset, offset never above DEPTH
  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] base);
    logic [IDX_W-1:0] res;
    if (base == '0) begin
      res = IDX_W'(DEPTH - 1);
    end else begin
      res = base - 1'b1;
    end
    return res;
  endfunction

endpackage

[rtl/bdq_ram.sv]
// ----------------------------------------------------------------------------
// bdq_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/bdq_front.sv]
// ----------------------------------------------------------------------------
// bdq_front
// accepts commands, decodes them and holds them in a short op queue
// ----------------------------------------------------------------------------
module bdq_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  bdq_pkg::in_item_t  in_item,
  output logic               op_valid,
  output bdq_pkg::op_t       op,
  input  logic               op_take
);
  import bdq_pkg::*;

  localparam int QDEPTH  = 2;
  localparam int Q_PTR_W = $clog2(QDEPTH);
  localparam int Q_CNT_W = $clog2(QDEPTH + 1);

  op_t                q_r [QDEPTH];
  logic [Q_PTR_W-1:0] wptr_r, wptr_nxt;
  logic [Q_PTR_W-1:0] rptr_r, rptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;

  op_t  dec_op;
  logic dec_ok;
  logic enq;
  logic deq;

  // decode, unused codes are dropped here
  always_comb begin
    dec_op       = '0;
    dec_op.value = in_item.value;
    dec_ok       = 1'b1;
    unique case (in_item.cmd)
      CMD_PUSH_FRONT: begin
        dec_op.push     = 1'b1;
        dec_op.at_front = 1'b1;
      end
      CMD_PUSH_BACK: begin
        dec_op.push = 1'b1;
      end
      CMD_POP_FRONT: begin
        dec_op.pop      = 1'b1;
        dec_op.at_front = 1'b1;
      end
      CMD_POP_BACK: begin
        dec_op.pop = 1'b1;
      end
      CMD_DUMP: begin
        dec_op.dump = 1'b1;
      end
      default: begin
        dec_ok = 1'b0;
      end
    endcase
  end

  assign full     = (cnt_r == Q_CNT_W'(QDEPTH));
  assign op_valid = (cnt_r != '0);
  assign op       = q_r[rptr_r];
  assign enq      = push && !full && dec_ok;
  assign deq      = op_take && op_valid;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (enq) begin
      wptr_nxt = (wptr_r == Q_PTR_W'(QDEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (deq) begin
      rptr_nxt = (rptr_r == Q_PTR_W'(QDEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (enq && !deq) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (deq && !enq) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      q_r[wptr_r] <= dec_op;
    end
  end

endmodule

[rtl/bdq_back.sv]
// ----------------------------------------------------------------------------
// bdq_back
// executes ops on the ring store and queues results for the output
// ----------------------------------------------------------------------------
module bdq_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               op_valid,
  input  bdq_pkg::op_t       op,
  output logic               op_take,
  output logic               empty,
  input  logic               pop,
  output bdq_pkg::out_item_t out_item
);
  import bdq_pkg::*;

  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DUMP = 2'b10
  } state_t;

  typedef struct packed {
    logic [1:0] status;
    logic       last;
    logic       from_ram;
  } res_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] front_r, front_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             res_v_r, res_v_nxt;
  res_t             res_r, res_nxt;

  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic              re;
  logic [IDX_W-1:0]  raddr;
  logic [WORD_W-1:0] rdata;

  out_item_t           oq_r [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] oq_wptr_r;
  logic [OQ_PTR_W-1:0] oq_rptr_r;
  logic [OQ_CNT_W-1:0] oq_cnt_r, oq_cnt_nxt;
  logic [OQ_CNT_W:0]   occ;
  logic                space;
  logic                oq_pop;
  out_item_t           oq_in;

  bdq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (op.value),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // room for one more result, counting the one in the read stage
  assign occ   = {1'b0, oq_cnt_r} + {{OQ_CNT_W{1'b0}}, res_v_r};
  assign space = (occ < (OQ_CNT_W + 1)'(OQ_DEPTH));

  always_comb begin
    state_nxt = state_r;
    front_nxt = front_r;
    fill_nxt  = fill_r;
    idx_nxt   = idx_r;
    res_v_nxt = 1'b0;
    res_nxt   = '{status: STATUS_OK, last: 1'b1, from_ram: 1'b0};
    op_take   = 1'b0;
    we        = 1'b0;
    waddr     = front_r;
    re        = 1'b0;
    raddr     = front_r;
    unique case (state_r)
      S_IDLE: begin
        if (op_valid && space) begin
          op_take   = 1'b1;
          res_v_nxt = 1'b1;
          priority if (op.push) begin
            if (fill_r == CNT_W'(DEPTH)) begin
              res_nxt.status = STATUS_FULL;
            end else begin
              we       = 1'b1;
              fill_nxt = fill_r + 1'b1;
              if (op.at_front) begin
                waddr     = wrap_dec(front_r);
                front_nxt = wrap_dec(front_r);
              end else begin
                waddr = wrap_add(front_r, fill_r);
              end
            end
          end else if (op.pop) begin
            if (fill_r == '0) begin
              res_nxt.status = STATUS_EMPTY;
            end else begin
              re               = 1'b1;
              res_nxt.from_ram = 1'b1;
              fill_nxt         = fill_r - 1'b1;
              if (op.at_front) begin
                front_nxt = wrap_add(front_r, CNT_W'(1));
              end else begin
                raddr = wrap_add(front_r, fill_r - 1'b1);
              end
            end
          end else begin
            // dump: first word now, the rest from the dump state
            if (fill_r == '0) begin
              res_nxt.status = STATUS_EMPTY;
            end else begin
              re               = 1'b1;
              res_nxt.from_ram = 1'b1;
              res_nxt.last     = (fill_r == CNT_W'(1));
              if (fill_r != CNT_W'(1)) begin
                idx_nxt   = IDX_W'(1);
                state_nxt = S_DUMP;
              end
            end
          end
        end
      end
      S_DUMP: begin
        if (space) begin
          res_v_nxt        = 1'b1;
          re               = 1'b1;
          raddr            = wrap_add(front_r, CNT_W'(idx_r));
          res_nxt.from_ram = 1'b1;
          res_nxt.last     = (CNT_W'(idx_r) == fill_r - 1'b1);
          idx_nxt          = idx_r + 1'b1;
          if (res_nxt.last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result fifo
  assign empty    = (oq_cnt_r == '0);
  assign out_item = oq_r[oq_rptr_r];
  assign oq_pop   = pop && !empty;

  always_comb begin
    oq_in        = '0;
    oq_in.word   = res_r.from_ram ? rdata : '0;
    oq_in.status = res_r.status;
    oq_in.last   = res_r.last;
    oq_cnt_nxt   = oq_cnt_r;
    if (res_v_r && !oq_pop) begin
      oq_cnt_nxt = oq_cnt_r + 1'b1;
    end else if (oq_pop && !res_v_r) begin
      oq_cnt_nxt = oq_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      front_r   <= '0;
      fill_r    <= '0;
      idx_r     <= '0;
      res_v_r   <= 1'b0;
      oq_wptr_r <= '0;
      oq_rptr_r <= '0;
      oq_cnt_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      front_r  <= front_nxt;
      fill_r   <= fill_nxt;
      idx_r    <= idx_nxt;
      res_v_r  <= res_v_nxt;
      oq_cnt_r <= oq_cnt_nxt;
      if (res_v_r) begin
        oq_wptr_r <= oq_wptr_r + 1'b1;
      end
      if (oq_pop) begin
        oq_rptr_r <= oq_rptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (res_v_r) begin
      oq_r[oq_wptr_r] <= oq_in;
    end
  end

endmodule

[rtl/bounded_deque.sv]
// ----------------------------------------------------------------------------
// bounded_deque
// bounded double-ended queue of signed 32-bit words in a ring store
// ----------------------------------------------------------------------------
// Commands enter through a queue-style port (push/full) and results leave
// through another (empty/pop). Push front and push back answer ok, or full
// with the word dropped; pop front and pop back return the removed word or
// an empty status; dump streams every stored word front to back with last
// set on the back word, or gives one empty result on an empty store.
// Unused command codes are accepted and produce nothing. Every result
// carries last, so the final result of each transaction is marked. Pushes
// and pops are sustained at one transaction per clock while results are
// drained; a dump reads the stored words one at a time, as the ring store
// has a single read port, and no other op runs until it is done. On its
// way out a result passes the op queue and the registered store read,
// after which it waits in the result fifo until popped. The store needs
// no clearing pass after reset; only written slots are ever read.
// ----------------------------------------------------------------------------
module bounded_deque (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  bdq_pkg::in_item_t  in_item,
  output logic               empty,
  input  logic               pop,
  output bdq_pkg::out_item_t out_item
);
  import bdq_pkg::*;

  // decoded op between front and back
  logic op_valid;
  op_t  op;
  logic op_take;

  // front: takes transactions, drops unused codes, buffers ops
  bdq_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .op_valid (op_valid),
    .op       (op),
    .op_take  (op_take)
  );

  // back: owns the ring store, front pointer and fill count
  bdq_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_valid (op_valid),
    .op       (op),
    .op_take  (op_take),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule

[rtl/bdq_checker.sv]
// ----------------------------------------------------------------------------
// bdq_checker
// port-level checks of the bounded deque, bound to the top level
// ----------------------------------------------------------------------------
module bdq_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input bdq_pkg::out_item_t out_item
);
  import bdq_pkg::*;

  // nothing waits to be taken and input is open straight after reset
  a_empty_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> (empty && !full))
    else $error("result shown or input closed right after reset");

  // status is always a defined code
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_item.status == STATUS_OK || out_item.status == STATUS_EMPTY ||
                out_item.status == STATUS_FULL))
    else $error("undefined status code");

  // error answers carry a zero word and close their transaction
  a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_item.status != STATUS_OK) |-> (out_item.word == '0 && out_item.last))
    else $error("error answer with word or without last");

  // a waiting result is held until taken
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_item)))
    else $error("waiting result changed or vanished");

endmodule

bind bounded_deque bdq_checker u_bdq_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_item (out_item)
);

[sim/bounded_deque_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_tb
// self-checking bench for the bounded double-ended queue
// ----------------------------------------------------------------------------
// A short table of directed commands runs first: the empty and full cases,
// the extreme words, unused command codes and dumps. A run of random
// commands follows, grouped into fill, drain and mixed stretches. A shadow
// deque or a typed row predicts every result; the receiver compares each
// popped result field by field with the oldest prediction. Both sides idle at
// random, and once the receiver holds off long enough for the input to stall.
// ----------------------------------------------------------------------------
module bounded_deque_tb;
  import bdq_pkg::*;

  localparam int RANDOM_ITEMS = 70;
  localparam int LONG_HOLD    = 150;   // receiver hold-off, in cycles
  localparam int DRAIN_CYCLES = 32;    // quiet cycles after the last result
  localparam int TIMEOUT_NS   = 10_000_000;
  localparam int REPORT_LIMIT = 10;

  // modes of the random stretches
  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} stretch_mode_t;

  // one row of the directed table; want is used only where typed is set
  typedef struct {
    in_item_t  item;
    int        reps;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      push;
  logic      full;
  in_item_t  in_item;
  logic      empty;
  logic      pop;
  out_item_t out_item;

  // shadow copy of the deque
  logic signed [WORD_W-1:0] shadow_slots [DEPTH];
  int                       shadow_front;
  int                       shadow_fill;

  out_item_t step_results[$];     // results of the command just applied
  out_item_t pending_results[$];  // predicted, not yet popped
  stim_row_t stim_rows[$];

  int fail_count;
  bit tx_burst;      // sender runs without gaps while set
  bit rx_burst;      // receiver runs without gaps while set
  bit hold_request;  // asks the receiver for its long hold-off
  bit rx_holding;    // set while that hold-off lasts

  bounded_deque DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit, far above the slowest legal run
  initial begin
    #(TIMEOUT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) begin
      $display("[%0t] %s", $realtime, msg);
    end
  endtask

  // apply one command to the shadow deque, leaving its results in step_results
  task automatic deque_apply(input in_item_t it);
    out_item_t r;
    step_results.delete();
    r = '0;
    r.last = 1'b1;
    case (it.cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (shadow_fill >= DEPTH) begin
          // full: word dropped, nothing stored
          r.status = STATUS_FULL;
        end else begin
          if (it.cmd == CMD_PUSH_FRONT) begin
            shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
            shadow_slots[shadow_front] = it.value;
          end else begin
            shadow_slots[(shadow_front + shadow_fill) % DEPTH] = it.value;
          end
          shadow_fill++;
          r.status = STATUS_OK;
        end
        step_results.push_back(r);
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (shadow_fill == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          if (it.cmd == CMD_POP_FRONT) begin
            r.word = shadow_slots[shadow_front];
            shadow_front = (shadow_front + 1) % DEPTH;
          end else begin
            r.word = shadow_slots[(shadow_front + shadow_fill - 1) % DEPTH];
          end
          shadow_fill--;
          r.status = STATUS_OK;
        end
        step_results.push_back(r);
      end
      CMD_DUMP: begin
        if (shadow_fill == 0) begin
          r.status = STATUS_EMPTY;
          step_results.push_back(r);
        end else begin
          // front to back, last only on the back word
          for (int i = 0; i < shadow_fill; i++) begin
            r.word   = shadow_slots[(shadow_front + i) % DEPTH];
            r.status = STATUS_OK;
            r.last   = (i == shadow_fill - 1);
            step_results.push_back(r);
          end
        end
      end
      default: begin
        // unused codes: no result, state untouched
      end
    endcase
  endtask

  task automatic stim_row(input logic [2:0] c, input logic signed [WORD_W-1:0] v,
                          input int reps, input bit typed,
                          input logic [1:0] st, input logic signed [WORD_W-1:0] w);
    stim_row_t row;
    row.item.cmd   = c;
    row.item.value = v;
    row.reps       = reps;
    row.typed      = typed;
    row.want.word   = w;
    row.want.status = st;
    row.want.last   = 1'b1;
    stim_rows.push_back(row);
  endtask

  // offer one command transaction and record what it should produce
  task automatic offer(input in_item_t it, input bit typed, input out_item_t want);
    int gap;
    if ($urandom_range(0, 15) == 0) begin
      tx_burst = !tx_burst;
    end
    // no gaps while the receiver holds off, so the block backs up
    gap = (tx_burst || rx_holding) ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push    <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (full !== 1'b0);
    // accepted at this edge
    deque_apply(it);
    if (typed) begin
      pending_results.push_back(want);
    end else begin
      foreach (step_results[i]) begin
        pending_results.push_back(step_results[i]);
      end
    end
  endtask

  function automatic in_item_t random_item(input stretch_mode_t mode);
    in_item_t it;
    int roll;
    int push_pct;
    int pop_pct;
    int dump_pct;
    case (mode)
      MODE_FILL:  begin push_pct = 70; pop_pct = 15; dump_pct = 10; end
      MODE_DRAIN: begin push_pct = 15; pop_pct = 70; dump_pct = 10; end
      default:    begin push_pct = 40; pop_pct = 40; dump_pct = 15; end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < push_pct) begin
      it.cmd = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
    end else if (roll < push_pct + pop_pct) begin
      it.cmd = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
    end else if (roll < push_pct + pop_pct + dump_pct) begin
      it.cmd = CMD_DUMP;
    end else begin
      it.cmd = 3'($urandom_range(5, 7));
    end
    // extremes now and then, random words otherwise, pops included
    case ($urandom_range(0, 7))
      0:       it.value = 32'sh7fff_ffff;
      1:       it.value = 32'sh8000_0000;
      2:       it.value = '0;
      3:       it.value = -32'sd1;
      default: it.value = $urandom;
    endcase
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // receiver: pops results with random gaps and checks each one
  // ---------------------------------------------------------------------------
  initial begin
    out_item_t want;
    int gap;
    pop <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (hold_request) begin
        // long hold-off so the result side fills and the input stalls
        hold_request = 1'b0;
        rx_holding   = 1'b1;
        pop <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        rx_holding = 1'b0;
      end
      if ($urandom_range(0, 15) == 0) begin
        rx_burst = !rx_burst;
      end
      gap = rx_burst ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty !== 1'b0);
      // result transaction taken at this edge
      if (pending_results.size() == 0) begin
        note_failure($sformatf("unexpected result word %0d status %0d last %0b",
                               out_item.word, out_item.status, out_item.last));
      end else begin
        want = pending_results.pop_front();
        if (out_item.word !== want.word || out_item.status !== want.status ||
            out_item.last !== want.last) begin
          note_failure($sformatf(
            "result mismatch: word %0d/%0d status %0d/%0d last %0b/%0b (exp/act)",
            want.word, out_item.word, want.status, out_item.status,
            want.last, out_item.last));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender: reset, directed table, random stretches, then drain
  // ---------------------------------------------------------------------------
  initial begin
    in_item_t      it;
    out_item_t     want;
    stretch_mode_t mode;
    int            sent;

    fail_count   = 0;
    tx_burst     = 1'b0;
    rx_burst     = 1'b0;
    hold_request = 1'b0;
    rx_holding   = 1'b0;
    shadow_front = 0;
    shadow_fill  = 0;
    foreach (shadow_slots[i]) begin
      shadow_slots[i] = '0;
    end

    rst_n   <= 1'b0;
    push    <= 1'b0;
    in_item <= '0;

    // empty store: every pop and the dump answer empty
    stim_row(CMD_POP_FRONT,  32'sd5,          1, 1'b1, STATUS_EMPTY, '0);
    stim_row(CMD_POP_BACK,   -32'sd5,         1, 1'b1, STATUS_EMPTY, '0);
    stim_row(CMD_DUMP,       32'sh7fff_ffff,  1, 1'b1, STATUS_EMPTY, '0);
    // unused codes produce nothing
    stim_row(3'd5,           32'sh5555_5555,  1, 1'b0, STATUS_OK, '0);
    stim_row(3'd6,           32'shaaaa_aaaa,  1, 1'b0, STATUS_OK, '0);
    stim_row(3'd7,           -32'sd1,         1, 1'b0, STATUS_OK, '0);
    // single word is both front and back, popping it empties the store
    stim_row(CMD_PUSH_FRONT, 32'sh7fff_ffff,  1, 1'b1, STATUS_OK, '0);
    stim_row(CMD_POP_BACK,   '0,              1, 1'b1, STATUS_OK, 32'sh7fff_ffff);
    stim_row(CMD_PUSH_BACK,  32'sh8000_0000,  1, 1'b1, STATUS_OK, '0);
    stim_row(CMD_POP_FRONT,  '0,              1, 1'b1, STATUS_OK, 32'sh8000_0000);
    stim_row(CMD_POP_FRONT,  '0,              1, 1'b1, STATUS_EMPTY, '0);
    // two words, dumped then taken from both ends
    stim_row(CMD_PUSH_FRONT, '0,              1, 1'b1, STATUS_OK, '0);
    stim_row(CMD_PUSH_BACK,  -32'sd1,         1, 1'b1, STATUS_OK, '0);
    stim_row(CMD_DUMP,       '0,              1, 1'b0, STATUS_OK, '0);
    stim_row(CMD_POP_FRONT,  '0,              1, 1'b1, STATUS_OK, '0);
    stim_row(CMD_POP_BACK,   '0,              1, 1'b1, STATUS_OK, -32'sd1);
    // fill to the brim, then both pushes are refused
    stim_row(CMD_PUSH_BACK,  32'sh7fff_fff8,  DEPTH, 1'b0, STATUS_OK, '0);
    stim_row(CMD_PUSH_FRONT, 32'sd1,          1, 1'b1, STATUS_FULL, '0);
    stim_row(CMD_PUSH_BACK,  32'sd2,          1, 1'b1, STATUS_FULL, '0);
    stim_row(CMD_DUMP,       '0,              1, 1'b0, STATUS_OK, '0);
    stim_row(CMD_POP_BACK,   '0,              DEPTH, 1'b0, STATUS_OK, '0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed part; repeated rows step the word by one each time
    foreach (stim_rows[r]) begin
      for (int k = 0; k < stim_rows[r].reps; k++) begin
        it       = stim_rows[r].item;
        it.value = stim_rows[r].item.value + k;
        offer(it, stim_rows[r].typed, stim_rows[r].want);
      end
    end

    // random part; the receiver takes its long hold-off near the start
    hold_request = 1'b1;
    sent = 0;
    mode = MODE_FILL;
    want = '0;
    while (sent < RANDOM_ITEMS) begin
      if (sent % 10 == 0) begin
        mode = stretch_mode_t'($urandom_range(0, 2));
      end
      it = random_item(mode);
      offer(it, 1'b0, want);
      // unused codes are ignored by the block and are not counted
      if (it.cmd <= CMD_DUMP) begin
        sent++;
      end
    end
    push <= 1'b0;

    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
